>>> design/ild_pkg.sv
// ----------------------------------------------------------------------------
// ild_pkg: shared definitions of the integer literal parser
// Automaton state codes, character constants and the control state record.
// ----------------------------------------------------------------------------
package ild_pkg;

  localparam int DefValueBits = 32;
  localparam int StateBits    = 3;
  localparam int CharBits     = 8;
  localparam int OutValueBits = 32;
  localparam int DigitBits    = 4;
  localparam int GrowBits     = 4;

  localparam logic [StateBits-1:0] ST_START = 3'd0;
  localparam logic [StateBits-1:0] ST_DEC   = 3'd1;
  localparam logic [StateBits-1:0] ST_ZERO  = 3'd2;
  localparam logic [StateBits-1:0] ST_HEX   = 3'd3;
  localparam logic [StateBits-1:0] ST_OCT   = 3'd4;

  localparam logic [CharBits-1:0] CH_ZERO  = 8'h30;
  localparam logic [CharBits-1:0] CH_ONE   = 8'h31;
  localparam logic [CharBits-1:0] CH_SEVEN = 8'h37;
  localparam logic [CharBits-1:0] CH_NINE  = 8'h39;
  localparam logic [CharBits-1:0] CH_UP_A  = 8'h41;
  localparam logic [CharBits-1:0] CH_UP_F  = 8'h46;
  localparam logic [CharBits-1:0] CH_LO_A  = 8'h61;
  localparam logic [CharBits-1:0] CH_LO_F  = 8'h66;
  localparam logic [CharBits-1:0] CH_LO_X  = 8'h78;

  typedef enum logic [1:0] {
    BASE_NONE,
    BASE_8,
    BASE_10,
    BASE_16
  } base_e;

  typedef struct packed {
    logic [StateBits-1:0] state;
    logic                 rejected;
    logic                 overflow;
  } ctrl_t;

endpackage

>>> design/ild_in_stage.sv
// ----------------------------------------------------------------------------
// ild_in_stage: input register of the integer literal parser
// Holds one character item until the automaton stage takes it.
// ----------------------------------------------------------------------------
module ild_in_stage
  import ild_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [CharBits-1:0] s_axis_tdata_i,   // character
  input  logic                s_axis_tlast_i,   // last_char
  input  logic                take_i,
  output logic                vld_o,
  output logic [CharBits-1:0] char_o,
  output logic                last_o
);

  logic                vld_q, vld_d;
  logic [CharBits-1:0] char_q;
  logic                last_q;
  logic                load;

  assign s_axis_tready_o = !vld_q || take_i;
  assign load            = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    vld_d = vld_q;
    if (load) begin
      vld_d = 1'b1;
    end else if (take_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= s_axis_tdata_i;
      last_q <= s_axis_tlast_i;
    end
  end

  assign vld_o  = vld_q;
  assign char_o = char_q;
  assign last_o = last_q;

endmodule

>>> design/ild_step.sv
// ----------------------------------------------------------------------------
// ild_step: one automaton step of the integer literal parser
// Decodes a character, moves the automaton and folds the digit into the value.
// ----------------------------------------------------------------------------
module ild_step
  import ild_pkg::*;
#(
  parameter int VALUE_BITS = DefValueBits
) (
  input  ctrl_t                 ctrl_i,
  input  logic [VALUE_BITS-1:0] acc_i,
  input  logic [CharBits-1:0]   char_i,
  output ctrl_t                 ctrl_o,
  output logic [VALUE_BITS-1:0] acc_o
);

  localparam int WideBits = VALUE_BITS + GrowBits;

  logic                 is_dec, is_oct, is_lo_hex, is_up_hex, is_hex;
  logic [DigitBits-1:0] digit;
  base_e                base;
  ctrl_t                ctrl_n;
  logic [WideBits-1:0]  acc_w, scaled, sum;

  always_comb begin
    is_dec    = (char_i >= CH_ZERO) && (char_i <= CH_NINE);
    is_oct    = (char_i >= CH_ZERO) && (char_i <= CH_SEVEN);
    is_lo_hex = (char_i >= CH_LO_A) && (char_i <= CH_LO_F);
    is_up_hex = (char_i >= CH_UP_A) && (char_i <= CH_UP_F);
    is_hex    = is_dec || is_lo_hex || is_up_hex;
    priority if (is_lo_hex) begin
      digit = DigitBits'(char_i - CH_LO_A + 8'd10);
    end else if (is_up_hex) begin
      digit = DigitBits'(char_i - CH_UP_A + 8'd10);
    end else begin
      digit = DigitBits'(char_i - CH_ZERO);
    end
  end

  always_comb begin
    ctrl_n = ctrl_i;
    base   = BASE_NONE;
    if (!ctrl_i.rejected) begin
      unique case (ctrl_i.state)
        ST_START: begin
          if (char_i == CH_ZERO) begin
            ctrl_n.state = ST_ZERO;
          end else if ((char_i >= CH_ONE) && (char_i <= CH_NINE)) begin
            ctrl_n.state = ST_DEC;
            base         = BASE_10;
          end else begin
            ctrl_n.rejected = 1'b1;
          end
        end
        ST_DEC: begin
          if (is_dec) base = BASE_10;
          else ctrl_n.rejected = 1'b1;
        end
        ST_ZERO: begin
          if (char_i == CH_LO_X) begin
            ctrl_n.state = ST_HEX;
          end else if (is_oct) begin
            ctrl_n.state = ST_OCT;
            base         = BASE_8;
          end else begin
            ctrl_n.rejected = 1'b1;
          end
        end
        ST_HEX: begin
          if (is_hex) base = BASE_16;
          else ctrl_n.rejected = 1'b1;
        end
        ST_OCT: begin
          if (is_oct) base = BASE_8;
          else ctrl_n.rejected = 1'b1;
        end
        default: begin
          ctrl_n.rejected = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    acc_w = WideBits'(acc_i);
    unique case (base)
      BASE_8:    scaled = acc_w << 3;
      BASE_10:   scaled = (acc_w << 3) + (acc_w << 1);
      BASE_16:   scaled = acc_w << 4;
      default:   scaled = acc_w;
    endcase
    sum    = scaled + WideBits'(digit);
    ctrl_o = ctrl_n;
    acc_o  = acc_i;
    if (base != BASE_NONE) begin
      acc_o = sum[VALUE_BITS-1:0];
      if (|sum[WideBits-1:VALUE_BITS]) begin
        ctrl_o.overflow = 1'b1;
      end
    end
  end

endmodule

>>> design/integer_literal_dfa_parser.sv
// ----------------------------------------------------------------------------
// integer_literal_dfa_parser: decimal, octal and hex integer literal parser
// Streams one character a cycle through a five-state automaton.
// ----------------------------------------------------------------------------
// Usage: each input item on the s_axis channel carries one ASCII character
// in tdata, and tlast marks the final character of a token. Characters that
// are not last give no result. On the last character one result item leaves
// on m_axis: tdata holds the value, tuser holds the accepted and overflow
// flags. A rejected token gives value zero and both flags clear.
// The last character is held in the input register, which feeds the step; the
// result register takes the step's outcome. Throughput: one character per cycle
// while no last character waits on a stalled result, set by the combinational
// automaton step between the two registers.
// A stalled receiver holds the result register; characters that give no
// result keep flowing, and only a further last character waits.
// Reset puts the automaton in its start state with a zero value and empties
// both registers. After each result the automaton returns to that state.
module integer_literal_dfa_parser
  import ild_pkg::*;
#(
  parameter int VALUE_BITS = DefValueBits
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  logic [CharBits-1:0]     s_axis_tdata_i,   // [7:0] character
  input  logic                    s_axis_tlast_i,   // last_char
  output logic                    m_axis_tvalid_o,
  input  logic                    m_axis_tready_i,
  output logic [OutValueBits-1:0] m_axis_tdata_o,   // [31:0] value
  output logic [1:0]              m_axis_tuser_o    // [0] accepted, [1] overflowed
);

  localparam int ExtBits = (VALUE_BITS > OutValueBits) ? VALUE_BITS : OutValueBits;

  logic                    in_vld, in_last, take, load_out, ok;
  logic [CharBits-1:0]     in_char;
  ctrl_t                   ctrl_q, ctrl_d, step_ctrl;
  logic [VALUE_BITS-1:0]   acc_q, acc_d, step_acc;
  logic [ExtBits-1:0]      acc_ext;
  logic                    out_vld_q, out_vld_d;
  logic [OutValueBits-1:0] out_value_q;
  logic                    out_acc_q, out_ovf_q;

  assign take     = in_vld && !(in_last && out_vld_q && !m_axis_tready_i);
  assign load_out = take && in_last;

  ild_in_stage u_in_stage (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tlast_i,
    .take_i (take),
    .vld_o  (in_vld),
    .char_o (in_char),
    .last_o (in_last)
  );

  ild_step #(
    .VALUE_BITS (VALUE_BITS)
  ) u_step (
    .ctrl_i (ctrl_q),
    .acc_i  (acc_q),
    .char_i (in_char),
    .ctrl_o (step_ctrl),
    .acc_o  (step_acc)
  );

  assign ok = !step_ctrl.rejected && (step_ctrl.state >= ST_DEC) &&
              (step_ctrl.state <= ST_OCT);
  assign acc_ext = ExtBits'(step_acc);

  always_comb begin
    ctrl_d = ctrl_q;
    acc_d  = acc_q;
    if (load_out) begin
      ctrl_d = '{state: ST_START, rejected: 1'b0, overflow: 1'b0};
      acc_d  = '0;
    end else if (take) begin
      ctrl_d = step_ctrl;
      acc_d  = step_acc;
    end
    out_vld_d = out_vld_q;
    if (load_out) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q    <= '{state: ST_START, rejected: 1'b0, overflow: 1'b0};
      acc_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      ctrl_q    <= ctrl_d;
      acc_q     <= acc_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_value_q <= ok ? acc_ext[OutValueBits-1:0] : '0;
      out_acc_q   <= ok;
      out_ovf_q   <= ok && step_ctrl.overflow;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_value_q;
  assign m_axis_tuser_o  = {out_ovf_q, out_acc_q};

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> (ctrl_q.state == ST_START) && !ctrl_q.rejected && !ctrl_q.overflow &&
                 (acc_q == '0))
    else $error("automaton did not restart after a result");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_acc_q) |-> ((out_value_q == '0) && !out_ovf_q))
    else $error("rejected token carries a value or overflow flag");

  a_last_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld && in_last && out_vld_q && !m_axis_tready_i) |=> (in_vld && in_last))
    else $error("pending last character lost while result stalled");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !m_axis_tready_i) |-> !load_out)
    else $error("result register overwritten while stalled");

endmodule
